FILE: sv/ssc_pkg.sv
// Shared types and constants for the split-screen text console.
// Used by ssc_ctrl, ssc_datapath and split_screen_text_console; no dependencies.
package ssc_pkg;

	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 25;
	localparam int WINDOW_COLS_DEF = 39;
	localparam int WIN_N           = 4;

	localparam int COLF_W   = 7;
	localparam int ROWF_W   = 5;
	localparam int CFG_IDX_W = 3;
	localparam int DIGITS   = 10;

	localparam logic [7:0] CH_HBAR     = 8'd205;
	localparam logic [7:0] CH_VBAR     = 8'd186;
	localparam logic [7:0] DIV_ATTR    = 8'd7;
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_HEX_BIAS = 8'd55;

	localparam logic [CFG_IDX_W-1:0] REG_WIN0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIV  = 3'd4;

	localparam logic [7:0] COLOR_RESET [WIN_N] = '{8'd13, 8'd4, 8'd2, 8'd6};

	typedef enum logic [2:0] {
		OP_PUT  = 3'd0,
		OP_NL   = 3'd1,
		OP_DEC  = 3'd2,
		OP_HEX  = 3'd3,
		OP_READ = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_CONV,
		ST_SKIP,
		ST_PUT,
		ST_NL,
		ST_SETTLE,
		ST_SC_RD,
		ST_SC_WR,
		ST_BLANK,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [1:0]  window;
		logic [7:0]  char_code;
		logic signed [31:0] number;
		logic [10:0] cell_index;
	} in_t;

	typedef struct packed {
		logic [15:0]       cell_data;
		logic [COLF_W-1:0] cursor_column;
		logic [ROWF_W-1:0] cursor_line;
	} out_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic conv;
		logic skip;
		logic put;
		logic nl;
		logic settle;
		logic next_digit;
		logic sc_rd;
		logic sc_wr;
		logic blank;
		logic read;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       negative;
		logic       clear_last;
		logic       conv_last;
		logic       skip_stop;
		logic       need_scroll;
		logic       more_digits;
		logic       sc_last_copy;
		logic       blank_last;
		logic       out_free;
	} sts_t;

endpackage

FILE: sv/split_screen_text_console.sv
// Split-screen text console: an 80x25 cell store cut into four 39x12 windows, each with
// its own cursor and color. After reset the block sweeps the whole store once, one cell a
// cycle, to clear it and draw the dividers; in_ready stays low during that pass,
// configuration writes are taken at any time. Items are handled one at a time through a
// single-port-write screen memory: a decimal number goes through binary-to-BCD conversion,
// then leading zero digits are skipped and each remaining digit is printed; hex does the
// same without the conversion. A scroll copies each cell of the window up one row, a read
// then a write, and then blanks the bottom row. The worst case is a ten-digit decimal that
// scrolls. The divider_color register is accepted but the dividers are always drawn with
// attribute 7.
module split_screen_text_console #(
	parameter int SCREEN_COLS = ssc_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = ssc_pkg::SCREEN_ROWS_DEF,
	parameter int WINDOW_COLS = ssc_pkg::WINDOW_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ssc_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ssc_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	ssc_pkg::cmd_t cmd;
	ssc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssc_datapath #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.WINDOW_COLS (WINDOW_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in flight");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.cursor_column) < SCREEN_COLS)
		else $error("cursor column outside the screen");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.cursor_line) < SCREEN_ROWS)
		else $error("cursor line outside the screen");
`endif

endmodule

FILE: sv/ssc_ctrl.sv
// Sequencer for the split-screen text console.
// Depends on ssc_pkg; drives ssc_datapath through cmd_t and watches sts_t.
module ssc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ssc_pkg::sts_t sts,
	output ssc_pkg::cmd_t cmd
);

	ssc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssc_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_d = ssc_pkg::ST_IDLE;
			end
			ssc_pkg::ST_IDLE: begin
				if (in_valid) state_d = ssc_pkg::ST_DISPATCH;
			end
			ssc_pkg::ST_DISPATCH: begin
				case (sts.op)
					ssc_pkg::OP_PUT:  state_d = ssc_pkg::ST_PUT;
					ssc_pkg::OP_NL:   state_d = ssc_pkg::ST_NL;
					ssc_pkg::OP_DEC:  state_d = sts.negative ? ssc_pkg::ST_DONE : ssc_pkg::ST_CONV;
					ssc_pkg::OP_HEX:  state_d = sts.negative ? ssc_pkg::ST_DONE : ssc_pkg::ST_SKIP;
					ssc_pkg::OP_READ: state_d = ssc_pkg::ST_READ;
					default:          state_d = ssc_pkg::ST_DONE;
				endcase
			end
			ssc_pkg::ST_CONV: begin
				if (sts.conv_last) state_d = ssc_pkg::ST_SKIP;
			end
			ssc_pkg::ST_SKIP: begin
				if (sts.skip_stop) state_d = ssc_pkg::ST_PUT;
			end
			ssc_pkg::ST_PUT:  state_d = ssc_pkg::ST_SETTLE;
			ssc_pkg::ST_NL:   state_d = ssc_pkg::ST_SETTLE;
			ssc_pkg::ST_SETTLE: begin
				if (sts.need_scroll)      state_d = ssc_pkg::ST_SC_RD;
				else if (sts.more_digits) state_d = ssc_pkg::ST_PUT;
				else                      state_d = ssc_pkg::ST_DONE;
			end
			ssc_pkg::ST_SC_RD: state_d = ssc_pkg::ST_SC_WR;
			ssc_pkg::ST_SC_WR: begin
				state_d = sts.sc_last_copy ? ssc_pkg::ST_BLANK : ssc_pkg::ST_SC_RD;
			end
			ssc_pkg::ST_BLANK: begin
				if (sts.blank_last)
					state_d = sts.more_digits ? ssc_pkg::ST_PUT : ssc_pkg::ST_DONE;
			end
			ssc_pkg::ST_READ: state_d = ssc_pkg::ST_DONE;
			ssc_pkg::ST_DONE: begin
				if (sts.out_free) state_d = ssc_pkg::ST_IDLE;
			end
			default: state_d = ssc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ssc_pkg::ST_CLEAR: cmd.clear = 1'b1;
			ssc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ssc_pkg::ST_CONV:  cmd.conv = 1'b1;
			ssc_pkg::ST_SKIP:  cmd.skip = !sts.skip_stop;
			ssc_pkg::ST_PUT:   cmd.put = 1'b1;
			ssc_pkg::ST_NL:    cmd.nl = 1'b1;
			ssc_pkg::ST_SETTLE: begin
				cmd.settle     = 1'b1;
				cmd.next_digit = !sts.need_scroll && sts.more_digits;
			end
			ssc_pkg::ST_SC_RD: cmd.sc_rd = 1'b1;
			ssc_pkg::ST_SC_WR: cmd.sc_wr = 1'b1;
			ssc_pkg::ST_BLANK: begin
				cmd.blank      = 1'b1;
				cmd.next_digit = sts.blank_last && sts.more_digits;
			end
			ssc_pkg::ST_READ:  cmd.read = 1'b1;
			ssc_pkg::ST_DONE:  cmd.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: sv/ssc_datapath.sv
// Datapath: screen memory, window cursors, colors, digit converter, result register.
// Depends on ssc_pkg; sequenced by ssc_ctrl through cmd_t.
module ssc_datapath #(
	parameter int SCREEN_COLS = ssc_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = ssc_pkg::SCREEN_ROWS_DEF,
	parameter int WINDOW_COLS = ssc_pkg::WINDOW_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssc_pkg::cmd_t                  cmd,
	output ssc_pkg::sts_t                  sts,
	input  ssc_pkg::in_t                   in_data,
	input  logic                           cfg_valid,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ssc_pkg::out_t                  out_data
);

	localparam int CELLS      = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = $clog2(SCREEN_COLS + 1);
	localparam int ROW_W      = $clog2(SCREEN_ROWS + 1);
	localparam int WIN_ROWS   = (SCREEN_ROWS - 1) / 2;
	localparam int RIGHT_LEFT = WINDOW_COLS + 2;

	function automatic logic [COL_W-1:0] f_left(input logic w0);
		return w0 ? COL_W'(RIGHT_LEFT) : '0;
	endfunction

	function automatic logic [COL_W-1:0] f_right(input logic w0);
		return w0 ? COL_W'(SCREEN_COLS) : COL_W'(WINDOW_COLS);
	endfunction

	function automatic logic [ROW_W-1:0] f_top(input logic w1);
		return w1 ? ROW_W'(WIN_ROWS + 1) : '0;
	endfunction

	function automatic logic [ADDR_W-1:0] f_addr(input logic [ROW_W-1:0] r,
	                                             input logic [COL_W-1:0] c);
		return ADDR_W'(r * SCREEN_COLS) + ADDR_W'(c);
	endfunction

	logic [15:0] mem [CELLS];

	logic [7:0]       color_q [ssc_pkg::WIN_N];
	logic [COL_W-1:0] cur_col_q [ssc_pkg::WIN_N];
	logic [ROW_W-1:0] cur_row_q [ssc_pkg::WIN_N];

	logic [2:0]  op_q;
	logic [1:0]  w_q;
	logic [7:0]  char_q;
	logic [10:0] cell_q;
	logic        neg_q;
	logic        printing_q;

	logic [30:0]                   bin_q;
	logic [4*ssc_pkg::DIGITS-1:0]  dig_q;
	logic [4:0]                    conv_cnt_q;
	logic [3:0]                    idx_q;

	logic [ROW_W-1:0]  sc_r_q;
	logic [COL_W-1:0]  sc_c_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ROW_W-1:0]  clr_r_q;
	logic [COL_W-1:0]  clr_c_q;
	logic [15:0]       rdata_q;

	logic          out_valid_q;
	ssc_pkg::out_t out_q;

	logic [COL_W-1:0] left_w, right_w, col_c, col_n;
	logic [ROW_W-1:0] top_w, bottom_w, row_c, row_n;
	logic             wrap, need_scroll, in_range;
	logic [3:0]       cur_digit;
	logic [7:0]       glyph;
	logic [4*ssc_pkg::DIGITS-1:0] dig_adj;
	logic [15:0]      clr_val;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [15:0]       wdata;

	assign left_w   = f_left(w_q[0]);
	assign right_w  = f_right(w_q[0]);
	assign top_w    = f_top(w_q[1]);
	assign bottom_w = top_w + ROW_W'(WIN_ROWS);
	assign col_c    = cur_col_q[w_q];
	assign row_c    = cur_row_q[w_q];

	assign wrap        = col_c >= right_w;
	assign col_n       = wrap ? left_w : col_c;
	assign row_n       = row_c + ROW_W'(wrap);
	assign need_scroll = row_n >= bottom_w;
	assign in_range    = 32'(cell_q) < CELLS;

	assign cur_digit = dig_q[idx_q*4 +: 4];
	assign glyph = !printing_q ? char_q :
	               (cur_digit > 4'd9) ? ssc_pkg::CHAR_HEX_BIAS + {4'b0, cur_digit}
	                                  : ssc_pkg::CHAR_ZERO + {4'b0, cur_digit};

	// add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ssc_pkg::DIGITS; i++) begin
			dig_adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3
			                                              : dig_q[i*4 +: 4];
		end
	end

	// vertical divider wins over the horizontal one where they cross
	always_comb begin
		if (clr_c_q == COL_W'(WINDOW_COLS) || clr_c_q == COL_W'(WINDOW_COLS + 1))
			clr_val = {ssc_pkg::DIV_ATTR, ssc_pkg::CH_VBAR};
		else if (clr_r_q == ROW_W'(WIN_ROWS))
			clr_val = {ssc_pkg::DIV_ATTR, ssc_pkg::CH_HBAR};
		else
			clr_val = '0;
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_addr_q;
		wdata = clr_val;
		if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.put) begin
			we    = 1'b1;
			waddr = f_addr(row_c, col_c);
			wdata = {color_q[w_q], glyph};
		end else if (cmd.sc_wr) begin
			we    = 1'b1;
			waddr = f_addr(sc_r_q, sc_c_q);
			wdata = rdata_q;
		end else if (cmd.blank) begin
			we    = 1'b1;
			waddr = f_addr(sc_r_q, sc_c_q);
			wdata = '0;
		end
	end

	always_comb begin
		re    = cmd.sc_rd || (cmd.read && in_range);
		raddr = cmd.sc_rd ? f_addr(sc_r_q + ROW_W'(1), sc_c_q) : ADDR_W'(cell_q);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssc_pkg::WIN_N; i++) color_q[i] <= ssc_pkg::COLOR_RESET[i];
		end else if (cfg_valid) begin
			case (cfg_index)
				ssc_pkg::REG_WIN0: color_q[0] <= cfg_data;
				ssc_pkg::REG_WIN1: color_q[1] <= cfg_data;
				ssc_pkg::REG_WIN2: color_q[2] <= cfg_data;
				ssc_pkg::REG_WIN3: color_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_r_q    <= '0;
			clr_c_q    <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_c_q == COL_W'(SCREEN_COLS - 1)) begin
				clr_c_q <= '0;
				clr_r_q <= clr_r_q + ROW_W'(1);
			end else begin
				clr_c_q <= clr_c_q + COL_W'(1);
			end
		end
	end

	// item capture and digit conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			printing_q <= 1'b0;
		end else if (cmd.load) begin
			printing_q <= in_data.operation == ssc_pkg::OP_DEC ||
			              in_data.operation == ssc_pkg::OP_HEX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_data.operation;
			w_q        <= in_data.window;
			char_q     <= in_data.char_code;
			cell_q     <= in_data.cell_index;
			neg_q      <= in_data.number[31];
			bin_q      <= in_data.number[30:0];
			dig_q      <= (in_data.operation == ssc_pkg::OP_HEX) ?
			              {8'b0, in_data.number} : '0;
			conv_cnt_q <= '0;
			idx_q      <= 4'(ssc_pkg::DIGITS - 1);
		end else if (cmd.conv) begin
			dig_q      <= {dig_adj[4*ssc_pkg::DIGITS-2:0], bin_q[30]};
			bin_q      <= {bin_q[29:0], 1'b0};
			conv_cnt_q <= conv_cnt_q + 5'd1;
		end else if (cmd.skip || cmd.next_digit) begin
			idx_q <= idx_q - 4'd1;
		end
	end

	// cursors and scroll walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssc_pkg::WIN_N; i++) begin
				cur_col_q[i] <= f_left(i[0]);
				cur_row_q[i] <= f_top(i[1]);
			end
		end else if (cmd.put) begin
			cur_col_q[w_q] <= col_c + COL_W'(1);
		end else if (cmd.nl) begin
			cur_col_q[w_q] <= left_w;
			cur_row_q[w_q] <= row_c + ROW_W'(1);
		end else if (cmd.settle) begin
			cur_col_q[w_q] <= col_n;
			cur_row_q[w_q] <= need_scroll ? bottom_w - ROW_W'(1) : row_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.settle) begin
			sc_r_q <= top_w;
			sc_c_q <= left_w;
		end else if (cmd.sc_wr || cmd.blank) begin
			if (sc_c_q == right_w - COL_W'(1)) begin
				sc_c_q <= left_w;
				sc_r_q <= sc_r_q + ROW_W'(1);
			end else begin
				sc_c_q <= sc_c_q + COL_W'(1);
			end
		end
	end

	// result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.cell_data     <= (op_q == ssc_pkg::OP_READ && in_range) ? rdata_q : '0;
			out_q.cursor_column <= ssc_pkg::COLF_W'(col_c);
			out_q.cursor_line   <= ssc_pkg::ROWF_W'(row_c);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts              = '0;
		sts.op           = op_q;
		sts.negative     = neg_q;
		sts.clear_last   = clr_addr_q == ADDR_W'(CELLS - 1);
		sts.conv_last    = conv_cnt_q == 5'd30;
		sts.skip_stop    = idx_q == 4'd0 || cur_digit != 4'd0;
		sts.need_scroll  = need_scroll;
		sts.more_digits  = printing_q && idx_q != 4'd0;
		sts.sc_last_copy = sc_r_q == bottom_w - ROW_W'(2) && sc_c_q == right_w - COL_W'(1);
		sts.blank_last   = sc_c_q == right_w - COL_W'(1);
		sts.out_free     = !out_valid_q || out_ready;
	end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for split_screen_text_console: drives item, config and result
// channels, with random item gaps and result stalls, and compares every result with a screen predictor.
// Depends on ssc_pkg and the split_screen_text_console RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int COLS     = 80;
	localparam int ROWS     = 25;
	localparam int WCOLS    = 39;
	localparam int WROWS    = (ROWS - 1) / 2;
	localparam int CELLS    = COLS * ROWS;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	ssc_pkg::in_t                  in_data;
	logic                          out_valid;
	logic                          out_ready;
	ssc_pkg::out_t                 out_data;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	// predicted screen state
	logic [15:0] screen [CELLS];
	int          cur_col [ssc_pkg::WIN_N];
	int          cur_row [ssc_pkg::WIN_N];
	logic [7:0]  win_color [ssc_pkg::WIN_N];
	logic [7:0]  div_reg;

	ssc_pkg::out_t pending_cursor_q [$];
	int   mismatches;
	bit   idle_on;
	int   rx_hold;
	int   rx_wait;

	split_screen_text_console u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#10_000_000;
		$display("** split_screen_text_console: FAILED **");
		$finish;
	end

	function automatic int left_of(int w);
		return (w & 1) ? WCOLS + 2 : 0;
	endfunction

	function automatic int right_of(int w);
		return (w & 1) ? COLS : WCOLS;
	endfunction

	function automatic int top_of(int w);
		return (w & 2) ? WROWS + 1 : 0;
	endfunction

	task automatic screen_reset();
		for (int i = 0; i < CELLS; i++)
			screen[i] = '0;
		for (int i = 0; i < COLS; i++)
			screen[WROWS * COLS + i] = {ssc_pkg::DIV_ATTR, ssc_pkg::CH_HBAR};
		for (int i = 0; i < ROWS; i++) begin
			screen[i * COLS + WCOLS]     = {ssc_pkg::DIV_ATTR, ssc_pkg::CH_VBAR};
			screen[i * COLS + WCOLS + 1] = {ssc_pkg::DIV_ATTR, ssc_pkg::CH_VBAR};
		end
		for (int w = 0; w < ssc_pkg::WIN_N; w++) begin
			cur_col[w]   = left_of(w);
			cur_row[w]   = top_of(w);
			win_color[w] = ssc_pkg::COLOR_RESET[w];
		end
		div_reg = ssc_pkg::DIV_ATTR;
	endtask

	function automatic void scroll_up(int w);
		int bot;
		bot = top_of(w) + WROWS;
		for (int r = top_of(w); r + 1 < bot; r++)
			for (int c = left_of(w); c < right_of(w); c++)
				screen[r * COLS + c] = screen[(r + 1) * COLS + c];
		for (int c = left_of(w); c < right_of(w); c++)
			screen[(bot - 1) * COLS + c] = '0;
		cur_row[w] = bot - 1;
	endfunction

	function automatic void settle(int w);
		if (cur_col[w] >= right_of(w)) begin
			cur_col[w] = left_of(w);
			cur_row[w]++;
		end
		if (cur_row[w] >= top_of(w) + WROWS)
			scroll_up(w);
	endfunction

	function automatic void put_glyph(int w, logic [7:0] ch);
		int idx;
		idx = cur_row[w] * COLS + cur_col[w];
		if (idx < CELLS)
			screen[idx] = {win_color[w], ch};
		cur_col[w]++;
		settle(w);
	endfunction

	function automatic void show_number(int w, logic [31:0] raw, int base);
		logic [7:0] digs [12];
		int         n;
		int         d;
		n = 0;
		if (raw[31])
			return;
		if (raw == 0) begin
			put_glyph(w, ssc_pkg::CHAR_ZERO);
			return;
		end
		while (raw != 0) begin
			digs[n] = 8'(raw % base);
			n++;
			raw = raw / base;
		end
		while (n > 0) begin
			n--;
			d = int'(digs[n]);
			put_glyph(w, (d > 9) ? 8'(d + ssc_pkg::CHAR_HEX_BIAS)
			                     : 8'(d + ssc_pkg::CHAR_ZERO));
		end
	endfunction

	function automatic ssc_pkg::out_t console_step(ssc_pkg::in_t it);
		ssc_pkg::out_t res;
		int   w;
		w = int'(it.window);
		res.cell_data = '0;
		case (it.operation)
			ssc_pkg::OP_PUT: put_glyph(w, it.char_code);
			ssc_pkg::OP_NL: begin
				cur_row[w]++;
				cur_col[w] = left_of(w);
				settle(w);
			end
			ssc_pkg::OP_DEC: show_number(w, it.number, 10);
			ssc_pkg::OP_HEX: show_number(w, it.number, 16);
			ssc_pkg::OP_READ:
				if (it.cell_index < CELLS)
					res.cell_data = screen[it.cell_index];
			default: ;
		endcase
		res.cursor_column = ssc_pkg::COLF_W'(cur_col[w]);
		res.cursor_line   = ssc_pkg::ROWF_W'(cur_row[w]);
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin
		ssc_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cursor_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", out_data);
			end else begin
				want = pending_cursor_q.pop_front();
				if (out_data.cell_data !== want.cell_data ||
						out_data.cursor_column !== want.cursor_column ||
						out_data.cursor_line !== want.cursor_line) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: data %h/%h col %0d/%0d row %0d/%0d",
							want.cell_data, out_data.cell_data, want.cursor_column,
							out_data.cursor_column, want.cursor_line, out_data.cursor_line);
				end
			end
		end
	end

	// receiver: random stall per beat while idle_on is set, plus a long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
		end else if (rx_hold > 0) begin
			rx_hold   <= rx_hold - 1;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			if (idle_on) begin
				rx_wait   <= $urandom_range(0, 9);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end else if (rx_wait > 0) begin
			rx_wait   <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(ssc_pkg::in_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		pending_cursor_q.push_back(console_step(it));
	endtask

	task automatic send_op(ssc_pkg::op_t op, int w, logic [7:0] ch, logic [31:0] num,
	                       int cell_idx);
		ssc_pkg::in_t it;
		it.operation  = op;
		it.window     = 2'(w);
		it.char_code  = ch;
		it.number     = num;
		it.cell_index = 11'(cell_idx);
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_cursor_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [ssc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == ssc_pkg::REG_DIV)
			div_reg = val;
		else
			win_color[idx] = val;
		@(posedge clk);
	endtask

	function automatic ssc_pkg::in_t random_item();
		ssc_pkg::in_t it;
		int  pick;
		it   = ssc_pkg::in_t'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 40)      it.operation = ssc_pkg::OP_PUT;
		else if (pick < 50) it.operation = ssc_pkg::OP_NL;
		else if (pick < 65) it.operation = ssc_pkg::OP_DEC;
		else if (pick < 80) it.operation = ssc_pkg::OP_HEX;
		else if (pick < 97) it.operation = ssc_pkg::OP_READ;
		if ($urandom_range(0, 2) == 0)
			it.number = $urandom_range(0, 999);
		if ($urandom_range(0, 9) != 0)
			it.cell_index = 11'($urandom_range(0, CELLS - 1));
		return it;
	endfunction

	task automatic test_config_sweep(logic [7:0] base);
		write_reg(ssc_pkg::REG_WIN0, base);
		write_reg(ssc_pkg::REG_WIN1, ~base);
		write_reg(ssc_pkg::REG_WIN2, base ^ 8'h5A);
		write_reg(ssc_pkg::REG_WIN3, 8'hFF);
		write_reg(ssc_pkg::REG_DIV, base + 8'd3);
	endtask

	task automatic test_chars();
		send_op(ssc_pkg::OP_PUT, 0, 8'd0, 0, 0);
		send_op(ssc_pkg::OP_PUT, 0, 8'd255, 0, 0);
		send_op(ssc_pkg::OP_PUT, 1, 8'd10, 0, 0);
		send_op(ssc_pkg::OP_PUT, 2, 8'hA5, 0, 0);
		send_op(ssc_pkg::OP_NL, 3, 8'd0, 0, 0);
		send_op(ssc_pkg::OP_READ, 0, 0, 0, 0);
		send_op(ssc_pkg::OP_READ, 0, 0, 0, 1);
		send_op(ssc_pkg::OP_READ, 1, 0, 0, WCOLS + 2);
		wait_drained();
	endtask

	task automatic test_numbers();
		send_op(ssc_pkg::OP_DEC, 0, 0, 32'd0, 0);
		send_op(ssc_pkg::OP_HEX, 1, 0, 32'd0, 0);
		send_op(ssc_pkg::OP_DEC, 2, 0, 32'h8000_0000, 0);
		send_op(ssc_pkg::OP_HEX, 3, 0, 32'hFFFF_FFFF, 0);
		send_op(ssc_pkg::OP_HEX, 3, 0, 32'h7FFF_FFFF, 0);
		send_op(ssc_pkg::OP_HEX, 2, 0, 32'h0ABC_DEF9, 0);
		wait_drained();
	endtask

	task automatic test_reads_and_unused();
		send_op(ssc_pkg::OP_READ, 0, 0, 0, CELLS - 1);
		send_op(ssc_pkg::OP_READ, 0, 0, 0, WROWS * COLS + 5);
		send_op(ssc_pkg::OP_READ, 0, 0, 0, 2047);
		send_op(ssc_pkg::op_t'(3'd5), 1, 8'hFF, 32'hFFFF_FFFF, 2047);
		send_op(ssc_pkg::op_t'(3'd6), 2, 0, 0, 0);
		send_op(ssc_pkg::op_t'(3'd7), 3, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_wrap_and_scroll();
		// four 10-digit numbers run past the right edge
		repeat (4)
			send_op(ssc_pkg::OP_DEC, 1, 0, 32'h7FFF_FFFF, 0);
		repeat (13)
			send_op(ssc_pkg::OP_NL, 3, 0, 0, 0);
		send_op(ssc_pkg::OP_READ, 3, 0, 0, (2 * WROWS) * COLS + WCOLS + 2);
		send_op(ssc_pkg::OP_READ, 1, 0, 0, COLS + WCOLS + 2);
		wait_drained();
	endtask

	task automatic test_backpressure();
		bit keep;
		keep    = idle_on;
		idle_on = 1'b0;
		rx_hold = 400;
		repeat (30)
			send_item(random_item());
		wait_drained();
		idle_on = keep;
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_item(random_item());
		wait_drained();
	endtask

	initial begin
		arst_n     = 1'b0;
		mismatches = 0;
		idle_on    = 1'b1;
		rx_hold    = 0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		screen_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_chars();
		test_numbers();
		test_reads_and_unused();
		test_wrap_and_scroll();
		test_config_sweep(8'h00);
		test_backpressure();
		test_random(200);
		test_config_sweep(8'hFF);
		idle_on = 1'b0;
		test_random(200);
		idle_on = 1'b1;
		test_config_sweep(8'h3C);
		test_random(200);

		if (mismatches == 0)
			$display("** split_screen_text_console: PASSED **");
		else
			$display("** split_screen_text_console: FAILED **");
		$finish;
	end

endmodule

FILE: split_screen_text_console.f
sv/ssc_pkg.sv
sv/ssc_ctrl.sv
sv/ssc_datapath.sv
sv/split_screen_text_console.sv
tb/tb_top.sv
